// File: src/fr_pkg.sv
// shared types and constants for the fresnel reflectance pipeline
// no dependencies; used by every module of the block
package fr_pkg;

    localparam int DEF_COMPONENT_WIDTH = 16;

    localparam int ETA_W   = 16;          // refractive index, Q4.12
    localparam int Q_W     = 31;          // Q30 magnitudes up to 1.0
    localparam int PROD_W  = ETA_W + Q_W; // index times Q30 value
    localparam int DIFF_W  = PROD_W + 1;  // sums of two such products
    localparam int SQX_W   = 2 * Q_W;     // radicand width of the root units
    localparam int SINT_W  = 30;          // refracted sine, strictly below 1.0
    localparam int KR_W    = 16;

    localparam logic [ETA_W-1:0] ETA_ONE = 16'd4096;
    localparam logic [KR_W-1:0]  KR_ONE  = 16'h8000;

    typedef struct packed {
        logic en;
        logic valid;
    } t_stage_ctl;

    typedef struct packed {
        logic [Q_W-1:0]   c;
        logic [ETA_W-1:0] eta_i;
        logic [ETA_W-1:0] eta_t;
        logic             flag;
    } t_side;

endpackage

// File: src/fr_sqrt_pipe.sv
// pipelined integer square root, one root bit per register stage
// depends on fr_pkg (stage control struct)
module fr_sqrt_pipe #(
    parameter int RW     = 31,
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fr_pkg::t_stage_ctl    i_ctl,
    input  logic [2*RW-1:0]       i_x,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [RW-1:0]         o_root,
    output logic [SIDE_W-1:0]     o_side
);
    import fr_pkg::*;

    logic              r_v    [RW];
    logic [RW+1:0]     r_rem  [RW];
    logic [RW-1:0]     r_q    [RW];
    logic [2*RW-1:0]   r_x    [RW];
    logic [SIDE_W-1:0] r_side [RW];

    genvar k;
    for (k = 0; k < RW; k++) begin : g_stage
        localparam int I = RW - 1 - k;
        logic [RW+1:0]     rem_in, rem_sh, trial;
        logic [RW-1:0]     q_in;
        logic [2*RW-1:0]   x_in;
        logic [SIDE_W-1:0] side_in;
        logic              v_in, ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign q_in    = '0;
            assign x_in    = i_x;
            assign side_in = i_side;
            assign v_in    = i_ctl.valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign q_in    = r_q[k-1];
            assign x_in    = r_x[k-1];
            assign side_in = r_side[k-1];
            assign v_in    = r_v[k-1];
        end

        // bring down the next two radicand bits, try 4q+1
        assign rem_sh = {rem_in[RW-1:0], x_in[2*I+1 -: 2]};
        assign trial  = {q_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[k]  <= ge ? rem_sh - trial : rem_sh;
                r_q[k]    <= {q_in[RW-2:0], ge};
                r_x[k]    <= x_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_q[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

// File: src/fr_div_pipe.sv
// pipelined restoring divider, floor(num * 2^(STEPS-1) / den) for num < 2*den
// one quotient bit per register stage; depends on fr_pkg
module fr_div_pipe #(
    parameter int DW     = 48,
    parameter int STEPS  = 31,
    parameter int SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fr_pkg::t_stage_ctl    i_ctl,
    input  logic [DW:0]           i_num,
    input  logic [DW-1:0]         i_den,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [STEPS-1:0]      o_quot,
    output logic [SIDE_W-1:0]     o_side
);
    import fr_pkg::*;

    logic              r_v    [STEPS];
    logic [DW:0]       r_rem  [STEPS];
    logic [DW-1:0]     r_den  [STEPS];
    logic [STEPS-1:0]  r_q    [STEPS];
    logic [SIDE_W-1:0] r_side [STEPS];

    genvar k;
    for (k = 0; k < STEPS; k++) begin : g_stage
        logic [DW:0]       rem_t;
        logic [DW-1:0]     den_in;
        logic [STEPS-1:0]  q_in;
        logic [SIDE_W-1:0] side_in;
        logic              v_in, ge;

        if (k == 0) begin : g_first
            assign rem_t   = i_num;
            assign den_in  = i_den;
            assign q_in    = '0;
            assign side_in = i_side;
            assign v_in    = i_ctl.valid;
        end else begin : g_next
            // remainder stays below den, so the doubled value fits
            assign rem_t   = {r_rem[k-1][DW-1:0], 1'b0};
            assign den_in  = r_den[k-1];
            assign q_in    = r_q[k-1];
            assign side_in = r_side[k-1];
            assign v_in    = r_v[k-1];
        end

        assign ge = rem_t >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[k]  <= ge ? rem_t - {1'b0, den_in} : rem_t;
                r_den[k]  <= den_in;
                r_q[k]    <= {q_in[STEPS-2:0], ge};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_quot  = r_q[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule

// File: src/fresnel_reflectance_top.sv
// fresnel reflectance top level: dot product, root and divide pipelines
// depends on fr_pkg, fr_sqrt_pipe, fr_div_pipe
//
// Usage
//   Input channel: i_valid / o_ready with direction, normal (signed, fraction
//   COMPONENT_WIDTH-2 bits) and refractive index (Q4.12). Output channel:
//   o_valid / i_ready with reflectance (Q1.15) and the total-internal flag.
//   Every request gives exactly one result, in order.
//   From accept to o_valid, for any COMPONENT_WIDTH, a request passes
//   three stages of dot product and clamp, a 31-stage square root for the
//   incident sine, a 30-stage divider for the refracted sine, a second
//   31-stage root for its cosine, two 31-stage dividers in parallel for the
//   s and p ratios, and the product, squaring and output registers.
//   Throughput is one request per cycle while the receiver takes results; the
//   root and divider units are fully unrolled, one bit per stage.
//   The whole pipeline advances only while the output register is empty or
//   being taken, so a receiver stall freezes every stage and o_ready drops;
//   nothing is lost or repeated. Synchronous reset clears all valid bits.
module fresnel_reflectance_top #(
    parameter int COMPONENT_WIDTH = fr_pkg::DEF_COMPONENT_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [COMPONENT_WIDTH-1:0] i_dir_x,
    input  logic signed [COMPONENT_WIDTH-1:0] i_dir_y,
    input  logic signed [COMPONENT_WIDTH-1:0] i_dir_z,
    input  logic signed [COMPONENT_WIDTH-1:0] i_normal_x,
    input  logic signed [COMPONENT_WIDTH-1:0] i_normal_y,
    input  logic signed [COMPONENT_WIDTH-1:0] i_normal_z,
    input  logic [fr_pkg::ETA_W-1:0]          i_refr_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [fr_pkg::KR_W-1:0]           o_reflectance,
    output logic                              o_total_internal
);
    import fr_pkg::*;

    localparam int W   = COMPONENT_WIDTH;
    localparam int PW  = 2 * W;
    // scale a product of two fractions of W-2 bits to Q30
    localparam int SH  = PW - 34;
    localparam int SHR = (SH >= 0) ? SH : 0;
    localparam int SHL = (SH < 0) ? -SH : 0;
    localparam int SW  = $bits(t_side);

    localparam logic signed [35:0] DOT_ONE = 36'sd1 <<< 30;
    localparam logic [SQX_W-1:0]   Q60_ONE = SQX_W'(1) << 60;

    logic       adv;
    t_stage_ctl ctl_sq1, ctl_dv1, ctl_sq2, ctl_dv2;

    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // stage 1: component magnitude products
    logic signed [W-1:0] va [3];
    logic signed [W-1:0] vb [3];
    logic [PW-1:0]       r_pm   [3];
    logic                r_pneg [3];
    logic [ETA_W-1:0]    r_n1;
    logic                r_v1;

    assign va[0] = i_dir_x;
    assign va[1] = i_dir_y;
    assign va[2] = i_dir_z;
    assign vb[0] = i_normal_x;
    assign vb[1] = i_normal_y;
    assign vb[2] = i_normal_z;

    genvar j;
    for (j = 0; j < 3; j++) begin : g_mul
        logic [W-1:0] ma, mb;
        assign ma = va[j][W-1] ? W'(-va[j]) : W'(va[j]);
        assign mb = vb[j][W-1] ? W'(-vb[j]) : W'(vb[j]);
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_pm[j]   <= PW'(ma) * PW'(mb);
                r_pneg[j] <= va[j][W-1] ^ vb[j][W-1];
            end
        end
    end

    // stage 2: scale, sum, clamp, pick the side of the interface
    logic signed [35:0] term [3];
    logic signed [35:0] dot_sum, dot;
    logic [Q_W-1:0]     c_abs;
    t_side              side2, r_side2, r_side3;
    logic               r_v2, r_v3;
    logic [SQX_W-1:0]   r_c2;

    for (j = 0; j < 3; j++) begin : g_scale
        logic [63:0] e, s;
        assign e = 64'(r_pm[j]);
        assign s = (e >> SHR) << SHL;
        assign term[j] = r_pneg[j] ? -$signed({3'b000, s[32:0]})
                                   :  $signed({3'b000, s[32:0]});
    end

    always_comb begin
        dot_sum = term[0] + term[1] + term[2];
        if (dot_sum > DOT_ONE) begin
            dot = DOT_ONE;
        end else if (dot_sum < -DOT_ONE) begin
            dot = -DOT_ONE;
        end else begin
            dot = dot_sum;
        end
        c_abs = dot[35] ? Q_W'(-dot) : Q_W'(dot);
        side2.c = c_abs;
        // positive cosine: ray leaves the material
        if (dot > 0) begin
            side2.eta_i = r_n1;
            side2.eta_t = ETA_ONE;
        end else begin
            side2.eta_i = ETA_ONE;
            side2.eta_t = r_n1;
        end
        side2.flag = (r_n1 == '0);
    end

    // stages 1 to 3: index and side registers, cosine squared
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_n1    <= i_refr_index;
            r_side2 <= side2;
            r_c2    <= SQX_W'(r_side2.c) * SQX_W'(r_side2.c);
            r_side3 <= r_side2;
        end
    end

    // incident sine
    logic           v_sq1;
    logic [Q_W-1:0] sin_i;
    logic [SW-1:0]  side_sq1_raw;
    t_side          side_sq1;

    assign ctl_sq1 = '{en: adv, valid: r_v3};

    fr_sqrt_pipe #(.RW(Q_W), .SIDE_W(SW)) u_sqrt_sin_i (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_sq1),
        .i_x     (Q60_ONE - r_c2),
        .i_side  (r_side3),
        .o_valid (v_sq1),
        .o_root  (sin_i),
        .o_side  (side_sq1_raw)
    );
    assign side_sq1 = t_side'(side_sq1_raw);

    // stages 5 and 6: scaled sine and total internal reflection test
    logic [PROD_W-1:0] r_prod1;
    t_side             r_side5, r_side6;
    logic [PROD_W-2:0] r_num1;
    logic              r_v5, r_v6;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod1 <= PROD_W'(side_sq1.eta_i) * PROD_W'(sin_i);
            r_side5 <= side_sq1;
            r_num1  <= r_prod1[PROD_W-2:0];
            r_side6 <= '{c: r_side5.c, eta_i: r_side5.eta_i, eta_t: r_side5.eta_t,
                         flag: r_side5.flag
                               || (r_prod1 >= {1'b0, r_side5.eta_t, 30'b0})};
        end
    end

    // refracted sine
    logic              v_dv1;
    logic [SINT_W-1:0] sin_t;
    logic [SW-1:0]     side_dv1_raw;
    t_side             side_dv1;

    assign ctl_dv1 = '{en: adv, valid: r_v6};

    fr_div_pipe #(.DW(PROD_W - 2), .STEPS(SINT_W), .SIDE_W(SW)) u_div_sin_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_dv1),
        .i_num   (r_num1),
        .i_den   ({r_side6.eta_t, 29'b0}),
        .i_side  (r_side6),
        .o_valid (v_dv1),
        .o_quot  (sin_t),
        .o_side  (side_dv1_raw)
    );
    assign side_dv1 = t_side'(side_dv1_raw);

    // stage 7: refracted sine squared
    logic [2*SINT_W-1:0] r_st2;
    t_side               r_side7;
    logic                r_v7;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st2   <= (2*SINT_W)'(sin_t) * (2*SINT_W)'(sin_t);
            r_side7 <= side_dv1;
        end
    end

    // refracted cosine
    logic           v_sq2;
    logic [Q_W-1:0] cos_t;
    logic [SW-1:0]  side_sq2_raw;
    t_side          side_sq2;

    assign ctl_sq2 = '{en: adv, valid: r_v7};

    fr_sqrt_pipe #(.RW(Q_W), .SIDE_W(SW)) u_sqrt_cos_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_sq2),
        .i_x     (Q60_ONE - SQX_W'(r_st2)),
        .i_side  (r_side7),
        .o_valid (v_sq2),
        .o_root  (cos_t),
        .o_side  (side_sq2_raw)
    );
    assign side_sq2 = t_side'(side_sq2_raw);

    // stages 8 and 9: numerators and denominators of rs and rp
    logic [PROD_W-1:0] r_as, r_bs, r_ap, r_bp;
    logic [DIFF_W-1:0] r_ds, r_ns, r_dp, r_np;
    logic              r_flag8, r_flag9, r_v8, r_v9;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_as    <= PROD_W'(side_sq2.eta_t) * PROD_W'(side_sq2.c);
            r_bs    <= PROD_W'(side_sq2.eta_i) * PROD_W'(cos_t);
            r_ap    <= PROD_W'(side_sq2.eta_i) * PROD_W'(side_sq2.c);
            r_bp    <= PROD_W'(side_sq2.eta_t) * PROD_W'(cos_t);
            r_flag8 <= side_sq2.flag;
            r_ds    <= DIFF_W'(r_as) + DIFF_W'(r_bs);
            r_ns    <= (r_as >= r_bs) ? DIFF_W'(r_as - r_bs) : DIFF_W'(r_bs - r_as);
            r_dp    <= DIFF_W'(r_ap) + DIFF_W'(r_bp);
            r_np    <= (r_ap >= r_bp) ? DIFF_W'(r_ap - r_bp) : DIFF_W'(r_bp - r_ap);
            // a zero denominator needs both terms zero
            r_flag9 <= r_flag8 || ((r_as == '0) && (r_bs == '0))
                               || ((r_ap == '0) && (r_bp == '0));
        end
    end

    // rs and rp ratios
    logic           v_rs, v_rp, flag_rs, flag_rp;
    logic [Q_W-1:0] rs, rp;

    assign ctl_dv2 = '{en: adv, valid: r_v9};

    fr_div_pipe #(.DW(DIFF_W), .STEPS(Q_W), .SIDE_W(1)) u_div_rs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_dv2),
        .i_num   ({1'b0, r_ns}),
        .i_den   (r_ds),
        .i_side  (r_flag9),
        .o_valid (v_rs),
        .o_quot  (rs),
        .o_side  (flag_rs)
    );

    fr_div_pipe #(.DW(DIFF_W), .STEPS(Q_W), .SIDE_W(1)) u_div_rp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_dv2),
        .i_num   ({1'b0, r_np}),
        .i_den   (r_dp),
        .i_side  (r_flag9),
        .o_valid (v_rp),
        .o_quot  (rp),
        .o_side  (flag_rp)
    );

    // stage 10: squares; then output register
    logic [SQX_W-1:0] r_rs2, r_rp2;
    logic [SQX_W:0]   kr_sum;
    logic [16:0]      kr_full;
    logic             r_flag10, r_v10, r_out_valid, r_total;
    logic [KR_W-1:0]  r_kr;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rs2    <= SQX_W'(rs) * SQX_W'(rs);
            r_rp2    <= SQX_W'(rp) * SQX_W'(rp);
            r_flag10 <= flag_rs || flag_rp;
        end
    end

    assign kr_sum  = (SQX_W+1)'(r_rs2) + (SQX_W+1)'(r_rp2);
    assign kr_full = kr_sum[SQX_W:46];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_flag10) begin
                r_kr    <= KR_ONE;
                r_total <= 1'b1;
            end else begin
                r_kr    <= (kr_full > 17'(KR_ONE)) ? KR_ONE : kr_full[KR_W-1:0];
                r_total <= 1'b0;
            end
        end
    end

    // valid bits of the local stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v5        <= 1'b0;
            r_v6        <= 1'b0;
            r_v7        <= 1'b0;
            r_v8        <= 1'b0;
            r_v9        <= 1'b0;
            r_v10       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v5        <= v_sq1;
            r_v6        <= r_v5;
            r_v7        <= v_dv1;
            r_v8        <= v_sq2;
            r_v9        <= r_v8;
            r_v10       <= v_rs && v_rp;
            r_out_valid <= r_v10;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_reflectance    = r_kr;
    assign o_total_internal = r_total;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output register empty");

    a_flag_forces_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_total_internal) |-> (o_reflectance == KR_ONE))
        else $error("total internal flag without unit reflectance");

    a_kr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_reflectance <= KR_ONE))
        else $error("reflectance above one");

    a_ratio_units_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v_rs == v_rp)
        else $error("rs and rp dividers out of step");

endmodule
